[src/pbcm_pkg.sv]
`timescale 1ns / 1ps

package pbcm_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int PALETTE_COUNT = 4;
  localparam int ROM_PALETTES  = 4;
  localparam int ROM_IDX_W     = $clog2(ROM_PALETTES);
  localparam int PIDX_W        = (PALETTE_COUNT > 1) ? $clog2(PALETTE_COUNT) : 1;
  localparam int NUM_CH        = 3;

  localparam int CH_W       = FRAC_BITS + 1;
  localparam int ROM_COEF_W = 3;
  localparam int COEF_W     = FRAC_BITS + 3;
  localparam int PROD_W     = CH_W + COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int RES_W      = ACC_W - FRAC_BITS - 2;

  localparam logic [CH_W-1:0] ONE          = CH_W'(1) << FRAC_BITS;
  localparam logic [CH_W-1:0] LARGE_THRESH = ONE >> 2;
  localparam logic [CH_W-1:0] FRESH_THRESH = ONE >> 1;
  localparam logic [ACC_W-1:0] ROUND_HALF  = ACC_W'(1) << (FRAC_BITS + 1);

  // Input tdata layout, lowest bit first.
  localparam int RED_LSB      = 0;
  localparam int GREEN_LSB    = RED_LSB + CH_W;
  localparam int BLUE_LSB     = GREEN_LSB + CH_W;
  localparam int PROGRESS_LSB = BLUE_LSB + CH_W;
  localparam int SLOW_BIT     = PROGRESS_LSB + CH_W;
  localparam int LARGE_LSB    = SLOW_BIT + 1;
  localparam int FAST_BIT     = LARGE_LSB + CH_W;
  localparam int FRESH_LSB    = FAST_BIT + 1;
  localparam int IN_FIELDS_W  = FRESH_LSB + CH_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_FIELDS_W = NUM_CH * CH_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FRAME = 1'b1
  } op_t;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_CH-1:0][NUM_CH-1:0] coef_mat_t;

  // Coefficients in quarters, indexed by palette, input channel, output channel.
  localparam logic [ROM_COEF_W-1:0] PALETTE_ROM [ROM_PALETTES][NUM_CH][NUM_CH] = '{
    '{ '{3'd0, 3'd4, 3'd0}, '{3'd2, 3'd4, 3'd2}, '{3'd0, 3'd2, 3'd0} },
    '{ '{3'd4, 3'd0, 3'd0}, '{3'd4, 3'd2, 3'd1}, '{3'd3, 3'd3, 3'd0} },
    '{ '{3'd3, 3'd3, 3'd3}, '{3'd0, 3'd0, 3'd4}, '{3'd0, 3'd3, 3'd3} },
    '{ '{3'd1, 3'd4, 3'd1}, '{3'd0, 3'd3, 3'd2}, '{3'd0, 3'd0, 3'd4} }
  };

  function automatic logic [PIDX_W-1:0] next_palette(input logic [PIDX_W-1:0] p);
    logic [PIDX_W-1:0] res;
    if (p == PIDX_W'(PALETTE_COUNT - 1)) begin
      res = '0;
    end else begin
      res = p + PIDX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [ROM_IDX_W-1:0] rom_entry(input logic [PIDX_W-1:0] p);
    logic [PIDX_W+ROM_IDX_W-1:0] ext;
    ext = {{ROM_IDX_W{1'b0}}, p};
    return ext[ROM_IDX_W-1:0];
  endfunction

endpackage

[src/palette_blend_color_matrix_top.sv]
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// in_     | input     | in_tvalid/in_tready | in_tdata pixel and frame fields, in_tuser op
// out_    | output    | out_tvalid/out_tready | out_tdata recolored pixel
//
// A pixel transaction passes the input register, product register and output
// register before out_tvalid rises. A new transaction can be accepted on every
// cycle while the output is not stalled. A frame update produces no result and
// updates the palette state as it leaves the input register. Reset clears the
// palette index, blend weight and all valid flags. A stalled output holds the
// pipeline, while bubbles ahead of the stall are still filled.
module palette_blend_color_matrix_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: red_in, green_in, blue_in, new_progress, slow_phase_full,
  // large_beat, fast_phase_full, fresh_beat.
  input  logic [pbcm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Field: operation.
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: red_out, green_out, blue_out, zero padding.
  output logic [pbcm_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import pbcm_pkg::*;

  logic              a_valid_r, a_valid_nxt;
  op_t               a_op_r;
  logic [CH_W-1:0]   a_ch_r [NUM_CH];
  logic [CH_W-1:0]   a_progress_r;
  logic              a_slow_r;
  logic [CH_W-1:0]   a_large_r;
  logic              a_fast_r;
  logic [CH_W-1:0]   a_fresh_r;

  logic              b_valid_r, b_valid_nxt;
  logic [PROD_W-1:0] b_prod_r [NUM_CH][NUM_CH];
  logic [PROD_W-1:0] b_prod_nxt [NUM_CH][NUM_CH];

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [PIDX_W-1:0] palette_idx_r, palette_idx_nxt;
  logic [CH_W-1:0]   weight_r, weight_nxt;

  logic      out_free;
  logic      b_ready;
  logic      a_leave;
  logic      in_acc;
  logic      b_load;
  logic      out_load;
  logic      frame_upd;
  coef_mat_t coef;

  assign out_free  = !out_valid_r || out_tready;
  assign b_ready   = !b_valid_r || out_free;
  assign a_leave   = a_valid_r && ((a_op_r == OP_FRAME) || b_ready);
  assign in_tready = !a_valid_r || a_leave;
  assign in_acc    = in_tvalid && in_tready;
  assign b_load    = a_leave && (a_op_r == OP_PIXEL);
  assign out_load  = b_valid_r && out_free;
  assign frame_upd = a_leave && (a_op_r == OP_FRAME);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pbcm_coef u_coef (
    .palette_idx (palette_idx_r),
    .weight      (weight_r),
    .coef        (coef)
  );

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_acc) begin
      a_valid_nxt = 1'b1;
    end else if (a_leave) begin
      a_valid_nxt = 1'b0;
    end

    b_valid_nxt = b_valid_r;
    if (b_load) begin
      b_valid_nxt = 1'b1;
    end else if (out_free) begin
      b_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Frame update: saturate the weight and advance the palette up to twice.
  always_comb begin
    logic [PIDX_W-1:0] idx;
    idx        = palette_idx_r;
    weight_nxt = weight_r;
    if (frame_upd) begin
      weight_nxt = (a_progress_r > ONE) ? ONE : a_progress_r;
      if (a_slow_r && (a_large_r > LARGE_THRESH)) begin
        idx = next_palette(idx);
      end
      if (a_fast_r && (a_fresh_r > FRESH_THRESH)) begin
        idx = next_palette(idx);
      end
    end
    palette_idx_nxt = idx;
  end

  always_comb begin
    for (int l = 0; l < NUM_CH; l++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        b_prod_nxt[l][c] = PROD_W'(a_ch_r[c]) * PROD_W'(coef[c][l]);
      end
    end
  end

  // Sum the three products, round half up, drop the quarter scale and clamp.
  always_comb begin
    logic [ACC_W-1:0] acc;
    logic [RES_W-1:0] res;
    out_data_nxt = '0;
    for (int l = 0; l < NUM_CH; l++) begin
      acc = ACC_W'(b_prod_r[l][0]) + ACC_W'(b_prod_r[l][1]) + ACC_W'(b_prod_r[l][2])
          + ROUND_HALF;
      res = acc[ACC_W-1:FRAC_BITS+2];
      out_data_nxt[l*CH_W +: CH_W] = (res > RES_W'(ONE)) ? ONE : res[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      b_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      palette_idx_r <= '0;
      weight_r      <= '0;
    end else begin
      a_valid_r     <= a_valid_nxt;
      b_valid_r     <= b_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      palette_idx_r <= palette_idx_nxt;
      weight_r      <= weight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r       <= op_t'(in_tuser);
      a_ch_r[0]    <= in_tdata[RED_LSB +: CH_W];
      a_ch_r[1]    <= in_tdata[GREEN_LSB +: CH_W];
      a_ch_r[2]    <= in_tdata[BLUE_LSB +: CH_W];
      a_progress_r <= in_tdata[PROGRESS_LSB +: CH_W];
      a_slow_r     <= in_tdata[SLOW_BIT];
      a_large_r    <= in_tdata[LARGE_LSB +: CH_W];
      a_fast_r     <= in_tdata[FAST_BIT];
      a_fresh_r    <= in_tdata[FRESH_LSB +: CH_W];
    end
    if (b_load) begin
      b_prod_r <= b_prod_nxt;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[src/pbcm_coef.sv]
`timescale 1ns / 1ps

module pbcm_coef (
  input  logic [pbcm_pkg::PIDX_W-1:0] palette_idx,
  input  logic [pbcm_pkg::CH_W-1:0]   weight,
  output pbcm_pkg::coef_mat_t         coef
);
  import pbcm_pkg::*;

  logic [CH_W-1:0]      weight_inv;
  logic [ROM_IDX_W-1:0] base_entry;
  logic [ROM_IDX_W-1:0] next_entry;

  assign weight_inv = ONE - weight;
  assign base_entry = rom_entry(palette_idx);
  assign next_entry = rom_entry(next_palette(palette_idx));

  // Each coefficient is a multiple of one quarter, so every term is a short
  // shift-and-add of the weight.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int l = 0; l < NUM_CH; l++) begin
        coef[c][l] = COEF_W'(weight_inv) * COEF_W'(PALETTE_ROM[base_entry][c][l])
                   + COEF_W'(weight) * COEF_W'(PALETTE_ROM[next_entry][c][l]);
      end
    end
  end

endmodule
